// ----- sv/ssp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_pkg: shared types and constants of the servo status packet parser
// Holds the packet constants, the result status codes, the register indexes
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ssp_pkg;

   // packet format
   localparam int MAX_PARAMS   = 16;
   localparam int LEN_OVERHEAD = 2;
   localparam logic [7:0] HDR_BYTE = 8'hFF;
   localparam logic [7:0] LEN_MIN  = 8'(LEN_OVERHEAD);
   localparam logic [7:0] LEN_MAX  = 8'(MAX_PARAMS + LEN_OVERHEAD);

   // widths
   localparam int BYTE_W      = 8;
   localparam int STATUS_W    = 3;
   localparam int PCNT_W      = 5;
   localparam int PARAM_IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
   localparam int COUNT_W     = $clog2(MAX_PARAMS + LEN_OVERHEAD + 1);
   localparam int CMP_W       = (COUNT_W > PCNT_W) ? COUNT_W : PCNT_W;

   // configuration port
   localparam int CSR_DATA_W = 8;
   typedef enum logic {
      CSR_EXPECTED_ID   = 1'b0,
      CSR_EXPECTED_PCNT = 1'b1
   } ssp_csr_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 3'd0,
      ST_TIMEOUT  = 3'd1,
      ST_HEADER   = 3'd2,
      ST_ID       = 3'd3,
      ST_LENGTH   = 3'd4,
      ST_CHECKSUM = 3'd5,
      ST_SERVO    = 3'd6
   } ssp_status_type;

   // controller -> datapath
   typedef struct packed {
      logic           load_id;    // start checksum with the id byte
      logic           load_len;   // capture length, clear body counters
      logic           body_byte;  // absorb one body byte
      logic           res_load;   // load the result register
      ssp_status_type res_code;
      logic           res_err;    // result carries the reply error byte
      logic           res_drain;  // result is a parameter run, restart read index
      logic           rd_en;      // read parameter buffer at read index
      logic           rd_next;    // advance read index
   } ssp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_hdr;
      logic id_match;
      logic len_ok;
      logic body_last;
      logic cnt_ok;
      logic sum_ok;
      logic err_zero;
      logic no_params;
      logic drain_last;
   } ssp_sts_type;

endpackage
`default_nettype wire

// ----- sv/ssp_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_req_if: request channel of the servo status packet parser
// One transaction is a received byte or a receive timeout.
// ----------------------------------------------------------------------------
interface ssp_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] rx_byte;

   modport source (output valid, output action, output rx_byte, input ready);
   modport sink   (input valid, input action, input rx_byte, output ready);
endinterface
`default_nettype wire

// ----- sv/ssp_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_rsp_if: response channel of the servo status packet parser
// One transaction is a fault/ok result or one parameter byte of a good reply.
// ----------------------------------------------------------------------------
interface ssp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] status;
   logic [7:0] servo_error_byte;
   logic [7:0] param_byte;
   logic       param_valid;
   logic       last;

   modport source (output valid, output status, output servo_error_byte,
                   output param_byte, output param_valid, output last,
                   input ready);
   modport sink   (input valid, input status, input servo_error_byte,
                   input param_byte, input param_valid, input last,
                   output ready);
endinterface
`default_nettype wire

// ----- sv/ssp_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ssp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  wire logic [WIDTH-1:0]                 wr_data,
   input  wire logic                             rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic      [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ----- sv/ssp_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_dp: datapath of the servo status packet parser
// Holds the config registers, body counters, checksum, reply error byte,
// parameter buffer and result register; reports byte checks to the controller.
// ----------------------------------------------------------------------------
module ssp_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic                          csr_index,
   input  wire logic [ssp_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic [ssp_pkg::BYTE_W-1:0]    rx_byte,
   input  wire ssp_pkg::ssp_cmd_type          cmd,
   output ssp_pkg::ssp_sts_type               sts,
   output logic [ssp_pkg::STATUS_W-1:0]       res_status,
   output logic [ssp_pkg::BYTE_W-1:0]         res_servo_error,
   output logic [ssp_pkg::BYTE_W-1:0]         res_param_byte,
   output logic                               res_param_valid,
   output logic                               res_last
);

   // configuration
   logic [ssp_pkg::BYTE_W-1:0] exp_id_ff;
   logic [ssp_pkg::PCNT_W-1:0] exp_pcnt_ff;

   // packet state
   logic [ssp_pkg::COUNT_W-1:0]     body_length_ff, body_length_in;
   logic [ssp_pkg::COUNT_W-1:0]     body_count_ff, body_count_in;
   logic [ssp_pkg::BYTE_W-1:0]      sum_ff, sum_in;
   logic [ssp_pkg::BYTE_W-1:0]      reply_err_ff, reply_err_in;
   logic [ssp_pkg::PARAM_IDX_W-1:0] rd_idx_ff, rd_idx_in;

   // result register
   ssp_pkg::ssp_status_type    out_status_ff;
   logic [ssp_pkg::BYTE_W-1:0] out_err_ff;
   logic                       out_drain_ff;

   logic [ssp_pkg::COUNT_W-1:0]     nparams;
   logic [ssp_pkg::COUNT_W-1:0]     count_m1;
   logic [ssp_pkg::COUNT_W-1:0]     rd_pos;
   logic                            ram_we;
   logic [ssp_pkg::BYTE_W-1:0]      ram_q;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_id_ff   <= '0;
         exp_pcnt_ff <= '0;
      end else if (csr_we) begin
         case (ssp_pkg::ssp_csr_type'(csr_index))
            ssp_pkg::CSR_EXPECTED_ID:   exp_id_ff   <= csr_wdata;
            ssp_pkg::CSR_EXPECTED_PCNT: exp_pcnt_ff <= csr_wdata[ssp_pkg::PCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // body counters, checksum and error byte
   always_comb begin
      body_length_in = body_length_ff;
      body_count_in  = body_count_ff;
      sum_in         = sum_ff;
      reply_err_in   = reply_err_ff;
      rd_idx_in      = rd_idx_ff;
      if (cmd.load_id) begin
         sum_in = rx_byte;
      end
      if (cmd.load_len) begin
         body_length_in = rx_byte[ssp_pkg::COUNT_W-1:0];
         body_count_in  = '0;
         reply_err_in   = '0;
         sum_in         = sum_ff + rx_byte;
      end
      if (cmd.body_byte) begin
         if (body_count_ff == '0) begin
            reply_err_in = rx_byte;
         end
         sum_in        = sum_ff + rx_byte;
         body_count_in = body_count_ff + ssp_pkg::COUNT_W'(1);
      end
      if (cmd.res_load && cmd.res_drain) begin
         rd_idx_in = '0;
      end
      if (cmd.rd_next) begin
         rd_idx_in = rd_idx_ff + ssp_pkg::PARAM_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         body_length_ff <= '0;
         body_count_ff  <= '0;
         sum_ff         <= '0;
         reply_err_ff   <= '0;
         rd_idx_ff      <= '0;
      end else begin
         body_length_ff <= body_length_in;
         body_count_ff  <= body_count_in;
         sum_ff         <= sum_in;
         reply_err_ff   <= reply_err_in;
         rd_idx_ff      <= rd_idx_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         out_status_ff <= cmd.res_code;
         out_err_ff    <= cmd.res_err ? reply_err_ff : '0;
         out_drain_ff  <= cmd.res_drain;
      end
   end

   // parameter buffer: body byte n (n >= 1) goes to entry n-1
   assign count_m1 = body_count_ff - ssp_pkg::COUNT_W'(1);
   assign ram_we   = cmd.body_byte && (body_count_ff != '0);

   ssp_ram #(
      .WIDTH (ssp_pkg::BYTE_W),
      .DEPTH (ssp_pkg::MAX_PARAMS)
   ) u_param_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_m1[ssp_pkg::PARAM_IDX_W-1:0]),
      .wr_data (rx_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (ram_q)
   );

   // checks reported to the controller
   assign nparams = body_length_ff - ssp_pkg::COUNT_W'(ssp_pkg::LEN_OVERHEAD);
   assign rd_pos  = ssp_pkg::COUNT_W'(rd_idx_ff) + ssp_pkg::COUNT_W'(1);

   always_comb begin
      sts.is_hdr     = (rx_byte == ssp_pkg::HDR_BYTE);
      sts.id_match   = (rx_byte == exp_id_ff);
      sts.len_ok     = (rx_byte >= ssp_pkg::LEN_MIN) && (rx_byte <= ssp_pkg::LEN_MAX);
      sts.body_last  = ((body_count_ff + ssp_pkg::COUNT_W'(1)) >= body_length_ff);
      sts.cnt_ok     = (ssp_pkg::CMP_W'(nparams) == ssp_pkg::CMP_W'(exp_pcnt_ff));
      sts.sum_ok     = ((~sum_ff) == rx_byte);
      sts.err_zero   = (reply_err_ff == '0);
      sts.no_params  = (nparams == '0);
      sts.drain_last = (rd_pos == nparams);
   end

   // result fields
   assign res_status      = out_status_ff;
   assign res_servo_error = out_err_ff;
   assign res_param_byte  = out_drain_ff ? ram_q : '0;
   assign res_param_valid = out_drain_ff;
   assign res_last        = out_drain_ff ? sts.drain_last : 1'b1;

   // body counter never passes the captured length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      body_count_ff <= body_length_ff)
      else $error("body count beyond body length");

endmodule
`default_nettype wire

// ----- sv/ssp_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ssp_ctrl: controller of the servo status packet parser
// Walks header, id, length and body phases, orders the end-of-body checks
// and sequences the parameter run out of the buffer.
// ----------------------------------------------------------------------------
module ssp_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_action,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire ssp_pkg::ssp_sts_type sts,
   output ssp_pkg::ssp_cmd_type      cmd
);

   typedef enum logic [2:0] {
      S_HDR1,
      S_HDR2,
      S_ID,
      S_LEN,
      S_BODY,
      S_RESP,
      S_FETCH,
      S_PARAM
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign req_ready = (state_ff inside {S_HDR1, S_HDR2, S_ID, S_LEN, S_BODY});
   assign rsp_valid = (state_ff == S_RESP) || (state_ff == S_PARAM);
   assign accept    = req_valid && req_ready;

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.res_code = ssp_pkg::ST_OK;
      if (accept && req_action) begin
         // timeout in any parse phase
         cmd.res_load = 1'b1;
         cmd.res_code = ssp_pkg::ST_TIMEOUT;
         state_in     = S_RESP;
      end else begin
         case (state_ff)
            S_HDR1, S_HDR2: begin
               if (accept) begin
                  if (!sts.is_hdr) begin
                     cmd.res_load = 1'b1;
                     cmd.res_code = ssp_pkg::ST_HEADER;
                     state_in     = S_RESP;
                  end else begin
                     state_in = (state_ff == S_HDR1) ? S_HDR2 : S_ID;
                  end
               end
            end
            S_ID: begin
               if (accept) begin
                  if (!sts.id_match) begin
                     cmd.res_load = 1'b1;
                     cmd.res_code = ssp_pkg::ST_ID;
                     state_in     = S_RESP;
                  end else begin
                     cmd.load_id = 1'b1;
                     state_in    = S_LEN;
                  end
               end
            end
            S_LEN: begin
               if (accept) begin
                  if (!sts.len_ok) begin
                     cmd.res_load = 1'b1;
                     cmd.res_code = ssp_pkg::ST_LENGTH;
                     state_in     = S_RESP;
                  end else begin
                     cmd.load_len = 1'b1;
                     state_in     = S_BODY;
                  end
               end
            end
            S_BODY: begin
               if (accept) begin
                  if (!sts.body_last) begin
                     cmd.body_byte = 1'b1;
                  end else begin
                     // checksum byte: count, then checksum, then servo error
                     cmd.res_load = 1'b1;
                     state_in     = S_RESP;
                     if (!sts.cnt_ok) begin
                        cmd.res_code = ssp_pkg::ST_LENGTH;
                     end else if (!sts.sum_ok) begin
                        cmd.res_code = ssp_pkg::ST_CHECKSUM;
                        cmd.res_err  = 1'b1;
                     end else if (!sts.err_zero) begin
                        cmd.res_code = ssp_pkg::ST_SERVO;
                        cmd.res_err  = 1'b1;
                     end else if (sts.no_params) begin
                        cmd.res_code = ssp_pkg::ST_OK;
                        cmd.res_err  = 1'b1;
                     end else begin
                        cmd.res_code  = ssp_pkg::ST_OK;
                        cmd.res_err   = 1'b1;
                        cmd.res_drain = 1'b1;
                        state_in      = S_FETCH;
                     end
                  end
               end
            end
            S_RESP: begin
               if (rsp_ready) begin
                  state_in = S_HDR1;
               end
            end
            S_FETCH: begin
               cmd.rd_en = 1'b1;
               state_in  = S_PARAM;
            end
            S_PARAM: begin
               if (rsp_ready) begin
                  if (sts.drain_last) begin
                     state_in = S_HDR1;
                  end else begin
                     cmd.rd_next = 1'b1;
                     state_in    = S_FETCH;
                  end
               end
            end
            default: state_in = S_HDR1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_HDR1;
      end else begin
         state_ff <= state_in;
      end
   end

   // input and output sides never both open
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request and response open together");

   // a timeout always produces a single result next
   a_timeout_resp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action) |=> (state_ff == S_RESP))
      else $error("timeout did not produce a result");

   // a buffer read is always followed by its parameter result
   a_fetch_param: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH) |=> (state_ff == S_PARAM) && rsp_valid)
      else $error("parameter read not presented");

endmodule
`default_nettype wire

// ----- sv/servo_status_packet_parser_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// servo_status_packet_parser_top: servo status reply parser
// Checks a status reply byte by byte and reports one fault or the parameters.
// ----------------------------------------------------------------------------
// While parsing, one byte or timeout transaction is accepted per clock. A
// transaction that ends a packet closes the request side until its results
// are taken: a fault or an empty good reply is one result, visible the cycle
// after the closing byte; a good reply with N parameters is a run of N
// results; each is read out of the registered-read parameter buffer and then
// held until taken. Parsing restarts with the first header byte once the last
// result is taken.
// Configuration registers: index 0 expected id, index 1 expected parameter
// count; write them only while no packet is in progress.
// ----------------------------------------------------------------------------
module servo_status_packet_parser_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   ssp_req_if.sink                             req_ch,
   ssp_rsp_if.source                           rsp_ch,
   input  wire logic                           csr_we,
   input  wire logic                           csr_index,
   input  wire logic [ssp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   ssp_pkg::ssp_cmd_type cmd;
   ssp_pkg::ssp_sts_type sts;

   // sequencing
   ssp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_action (req_ch.action),
      .req_ready  (req_ch.ready),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // checks, storage and result fields
   ssp_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rx_byte         (req_ch.rx_byte),
      .cmd             (cmd),
      .sts             (sts),
      .res_status      (rsp_ch.status),
      .res_servo_error (rsp_ch.servo_error_byte),
      .res_param_byte  (rsp_ch.param_byte),
      .res_param_valid (rsp_ch.param_valid),
      .res_last        (rsp_ch.last)
   );

endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench of the servo status packet parser
// Feeds received bytes and receive timeouts into the parser, predicts every
// fault, ok and parameter result in the testbench, and compares each result
// transaction field by field. The tests cover directed framing and body
// checks, the configuration extremes, output back-pressure, a stream with no
// idling and a long run of random, mostly well-formed replies.
// ----------------------------------------------------------------------------
module tb;
   import ssp_pkg::*;

   localparam int RESET_CYCLES  = 12;
   localparam int IDLE_PCT      = 23;
   localparam int HOLD_CYCLES   = 200;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 20;
   localparam int RANDOM_ITEMS  = 110;
   localparam int LIMIT_CYCLES  = 300000;

   // parser phase as tracked by the predictor
   typedef enum logic [2:0] {
      HUNT_HDR1,
      HUNT_HDR2,
      WAIT_ID,
      WAIT_LEN,
      IN_BODY
   } parse_phase_type;

   // one expected result transaction
   typedef struct {
      ssp_status_type status;
      logic [7:0]     err;
      logic [7:0]     pbyte;
      logic           pvalid;
      logic           last;
   } reply_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ssp_req_if req_ch ();
   ssp_rsp_if rsp_ch ();

   servo_status_packet_parser_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state and shadow configuration
   parse_phase_type parse_phase = HUNT_HDR1;
   logic [4:0] body_len  = '0;
   int         body_seen = 0;
   logic [7:0] csum      = '0;
   logic [7:0] reply_err = '0;
   logic [7:0] param_buf [MAX_PARAMS];
   logic [7:0] cfg_id    = '0;
   logic [4:0] cfg_pcnt  = '0;

   reply_type  pending_replies [$];
   logic [7:0] frame [$];

   int  errors        = 0;
   int  sent_items    = 0;
   int  results_seen  = 0;
   int  good_replies  = 0;
   int  fault_replies = 0;
   int  cycle_count   = 0;
   int  holds_asked   = 0;
   bit  no_idle       = 1'b0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   function automatic void add_reply(ssp_status_type s, logic [7:0] e, logic [7:0] p,
                                     logic v, logic l);
      reply_type r;
      r.status = s;
      r.err    = e;
      r.pbyte  = p;
      r.pvalid = v;
      r.last   = l;
      pending_replies.push_back(r);
   endfunction

   // a fault is a run of one and restarts the header hunt
   function automatic void add_fault(ssp_status_type s, logic [7:0] e);
      add_reply(s, e, 8'h00, 1'b0, 1'b1);
      parse_phase = HUNT_HDR1;
   endfunction

   function automatic void track_byte(logic act, logic [7:0] b);
      int nparams;
      int i;
      if (act) begin
         add_fault(ST_TIMEOUT, 8'h00);
         return;
      end
      case (parse_phase)
         HUNT_HDR1: begin
            if (b != HDR_BYTE) add_fault(ST_HEADER, 8'h00);
            else parse_phase = HUNT_HDR2;
         end
         HUNT_HDR2: begin
            if (b != HDR_BYTE) add_fault(ST_HEADER, 8'h00);
            else parse_phase = WAIT_ID;
         end
         WAIT_ID: begin
            if (b != cfg_id) add_fault(ST_ID, 8'h00);
            else begin
               csum        = b;
               parse_phase = WAIT_LEN;
            end
         end
         WAIT_LEN: begin
            if (b < LEN_MIN || b > LEN_MAX) add_fault(ST_LENGTH, 8'h00);
            else begin
               body_len    = b[4:0];
               body_seen   = 0;
               reply_err   = 8'h00;
               csum        = csum + b;
               parse_phase = IN_BODY;
            end
         end
         IN_BODY: begin
            if (body_seen + 1 >= body_len) begin
               // closing byte: count, then checksum, then servo error
               nparams = body_len - LEN_OVERHEAD;
               if (nparams != cfg_pcnt) add_fault(ST_LENGTH, 8'h00);
               else if (8'(~csum) != b) add_fault(ST_CHECKSUM, reply_err);
               else if (reply_err != 8'h00) add_fault(ST_SERVO, reply_err);
               else begin
                  parse_phase = HUNT_HDR1;
                  if (nparams == 0) add_reply(ST_OK, 8'h00, 8'h00, 1'b0, 1'b1);
                  else begin
                     for (i = 0; i < nparams; i++)
                        add_reply(ST_OK, 8'h00, param_buf[i], 1'b1, i == nparams - 1);
                  end
               end
            end else begin
               if (body_seen == 0) reply_err = b;
               else param_buf[body_seen-1] = b;
               csum      = csum + b;
               body_seen = body_seen + 1;
            end
         end
         default: parse_phase = HUNT_HDR1;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------
   task automatic send_item(input logic act, input logic [7:0] b);
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.action  <= act;
      req_ch.rx_byte <= b;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      sent_items++;
      track_byte(act, b);
   endtask

   task automatic send_head(input logic [7:0] id);
      send_item(1'b0, HDR_BYTE);
      send_item(1'b0, HDR_BYTE);
      send_item(1'b0, id);
   endtask

   // assemble a reply with random parameters; chk_flip spoils the checksum
   function automatic void build_reply(logic [7:0] id, int nparams, logic [7:0] err,
                                       logic [7:0] chk_flip);
      logic [7:0] len;
      logic [7:0] sum;
      logic [7:0] p;
      int i;
      len = 8'(nparams + LEN_OVERHEAD);
      sum = id + len + err;
      frame.delete();
      frame.push_back(HDR_BYTE);
      frame.push_back(HDR_BYTE);
      frame.push_back(id);
      frame.push_back(len);
      frame.push_back(err);
      for (i = 0; i < nparams; i++) begin
         p = 8'($urandom);
         frame.push_back(p);
         sum = sum + p;
      end
      frame.push_back(~sum ^ chk_flip);
   endfunction

   // send the first cut bytes of the frame; a short frame ends in a timeout
   task automatic send_frame(input int cut);
      int i;
      for (i = 0; i < cut; i++) send_item(1'b0, frame[i]);
      if (cut < frame.size()) send_item(1'b1, 8'($urandom));
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   // registers change only with no packet open and all results taken
   task automatic write_csr(input ssp_csr_type idx, input logic [7:0] data);
      if (parse_phase != HUNT_HDR1) send_item(1'b1, 8'($urandom));
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_EXPECTED_ID) cfg_id = data;
      else cfg_pcnt = data[4:0];
   endtask

   // ------------------------------------------------------------------------
   // result side: ready with random stalls and requested long hold-offs
   // ------------------------------------------------------------------------
   initial begin : drive_rsp_ready
      int hold_left;
      int holds_served;
      hold_left    = 0;
      holds_served = 0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (holds_served < holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // compare every accepted result with the oldest pending reply
   always @(posedge clock) begin : check_results
      reply_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         results_seen++;
         if (pending_replies.size() == 0) begin
            $error("result with no reply pending: status %0d param_byte %0h",
                   rsp_ch.status, rsp_ch.param_byte);
            errors++;
         end else begin
            want = pending_replies.pop_front();
            if (want.status != ST_OK) fault_replies++;
            else if (want.last) good_replies++;
            if (rsp_ch.status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
               errors++;
            end
            if (rsp_ch.servo_error_byte !== want.err) begin
               $error("servo_error_byte: expected %0h, actual %0h", want.err,
                      rsp_ch.servo_error_byte);
               errors++;
            end
            if (rsp_ch.param_byte !== want.pbyte) begin
               $error("param_byte: expected %0h, actual %0h", want.pbyte,
                      rsp_ch.param_byte);
               errors++;
            end
            if (rsp_ch.param_valid !== want.pvalid) begin
               $error("param_valid: expected %0b, actual %0b", want.pvalid,
                      rsp_ch.param_valid);
               errors++;
            end
            if (rsp_ch.last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_ch.last);
               errors++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // header, id and length faults, and a timeout in every phase
   task automatic test_framing();
      write_csr(CSR_EXPECTED_ID, 8'h01);
      write_csr(CSR_EXPECTED_PCNT, 8'h02);
      send_item(1'b1, 8'hA5);
      send_item(1'b0, 8'h00);
      send_item(1'b0, HDR_BYTE);
      send_item(1'b0, 8'hFE);
      send_head(8'h02);
      send_head(8'h01);
      send_item(1'b0, 8'h01);
      send_head(8'h01);
      send_item(1'b0, 8'd19);
      send_head(8'h01);
      send_item(1'b0, 8'h00);
      send_head(8'h01);
      send_item(1'b0, 8'hFF);
      send_item(1'b0, HDR_BYTE);
      send_item(1'b1, 8'h5A);
      send_item(1'b0, HDR_BYTE);
      send_item(1'b0, HDR_BYTE);
      send_item(1'b1, 8'hFF);
      send_head(8'h01);
      send_item(1'b1, 8'h00);
      build_reply(8'h01, 2, 8'h00, 8'h00);
      send_frame(4);
      build_reply(8'h01, 2, 8'h00, 8'h00);
      send_frame(5);
      build_reply(8'h01, 2, 8'h00, 8'h00);
      send_frame(6);
   endtask

   // end-of-body checks and their order
   task automatic test_body_checks();
      build_reply(8'h01, 2, 8'h00, 8'h00);
      send_frame(frame.size());
      build_reply(8'h01, 2, 8'h20, 8'h00);
      send_frame(frame.size());
      build_reply(8'h01, 2, 8'h00, 8'h01);
      send_frame(frame.size());
      // bad checksum wins over a servo error
      build_reply(8'h01, 2, 8'hFF, 8'h80);
      send_frame(frame.size());
      build_reply(8'h01, 3, 8'h00, 8'h00);
      send_frame(frame.size());
      // wrong count wins over checksum and servo error
      build_reply(8'h01, 1, 8'h04, 8'h01);
      send_frame(frame.size());
   endtask

   // empty reply, longest reply, id extremes and unreachable counts
   task automatic test_config_extremes();
      write_csr(CSR_EXPECTED_ID, 8'h00);
      write_csr(CSR_EXPECTED_PCNT, 8'h00);
      build_reply(8'h00, 0, 8'h00, 8'h00);
      send_frame(frame.size());
      build_reply(8'h00, 0, 8'h7F, 8'h00);
      send_frame(frame.size());
      write_csr(CSR_EXPECTED_ID, 8'hFF);
      write_csr(CSR_EXPECTED_PCNT, 8'(MAX_PARAMS));
      build_reply(8'hFF, MAX_PARAMS, 8'h00, 8'h00);
      send_frame(frame.size());
      build_reply(8'hFF, MAX_PARAMS - 1, 8'h00, 8'h00);
      send_frame(frame.size());
      write_csr(CSR_EXPECTED_PCNT, 8'(MAX_PARAMS + 1));
      build_reply(8'hFF, MAX_PARAMS, 8'h00, 8'h00);
      send_frame(frame.size());
      write_csr(CSR_EXPECTED_PCNT, 8'h1F);
      build_reply(8'hFF, MAX_PARAMS, 8'h00, 8'h00);
      send_frame(frame.size());
      build_reply(8'hFF, 0, 8'h00, 8'h00);
      send_frame(frame.size());
   endtask

   // long receiver hold-off while replies keep coming, then a full pause
   task automatic test_backpressure();
      write_csr(CSR_EXPECTED_PCNT, 8'h04);
      holds_asked++;
      no_idle = 1'b1;
      repeat (4) begin
         build_reply(cfg_id, 4, 8'h00, 8'h00);
         send_frame(frame.size());
      end
      no_idle = 1'b0;
      wait_drained();
   endtask

   // back-to-back traffic with no idling on either side
   task automatic test_steady_stream();
      write_csr(CSR_EXPECTED_ID, 8'h5A);
      write_csr(CSR_EXPECTED_PCNT, 8'h03);
      no_idle = 1'b1;
      repeat (8) begin
         build_reply(8'h5A, 3, ($urandom_range(3) == 0) ? 8'h01 : 8'h00, 8'h00);
         send_frame(frame.size());
      end
      send_item(1'b0, 8'h33);
      send_item(1'b1, 8'h00);
      no_idle = 1'b0;
   endtask

   // mostly well-formed replies with random content, some broken ones and noise
   task automatic test_random_traffic();
      int start;
      int r;
      int n;
      start = sent_items;
      while (sent_items - start < RANDOM_ITEMS) begin
         if ($urandom_range(99) < 8) begin
            r = $urandom_range(99);
            write_csr(CSR_EXPECTED_ID, (r < 10) ? 8'h00 : (r < 20) ? 8'hFF : 8'($urandom));
            r = $urandom_range(99);
            write_csr(CSR_EXPECTED_PCNT, (r < 60) ? 8'($urandom_range(4)) :
                      (r < 85) ? 8'($urandom_range(MAX_PARAMS, 5)) :
                      8'($urandom_range(31, MAX_PARAMS + 1)));
         end
         if (parse_phase != HUNT_HDR1 && $urandom_range(1) == 1)
            send_item(1'b1, 8'($urandom));
         n = (cfg_pcnt <= MAX_PARAMS) ? int'(cfg_pcnt) : $urandom_range(MAX_PARAMS);
         r = $urandom_range(99);
         if (r < 55) begin
            build_reply(cfg_id, n, ($urandom_range(9) == 0) ? 8'($urandom) : 8'h00, 8'h00);
            send_frame(frame.size());
         end else if (r < 65) begin
            build_reply(cfg_id, $urandom_range(MAX_PARAMS), 8'h00, 8'h00);
            send_frame(frame.size());
         end else if (r < 73) begin
            build_reply(cfg_id, n, 8'($urandom), 8'(1 << $urandom_range(7)));
            send_frame(frame.size());
         end else if (r < 81) begin
            // reply cut short by a timeout
            build_reply(cfg_id, n, 8'h00, 8'h00);
            send_frame($urandom_range(frame.size() - 1));
         end else if (r < 85) begin
            build_reply(8'($urandom), n, 8'h00, 8'h00);
            send_frame(frame.size());
         end else if (r < 90) begin
            build_reply(cfg_id, n, 8'h00, 8'h00);
            frame[3] = 8'($urandom);
            send_frame(frame.size());
         end else begin
            repeat ($urandom_range(4, 1))
               send_item($urandom_range(4) == 0,
                         ($urandom_range(3) == 0) ? HDR_BYTE : 8'($urandom));
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // run control
   // ------------------------------------------------------------------------
   initial begin
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.action  <= 1'b0;
      req_ch.rx_byte <= 8'h00;
      csr_we         <= 1'b0;
      csr_index      <= CSR_EXPECTED_ID;
      csr_wdata      <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_framing();
      test_body_checks();
      test_config_extremes();
      test_backpressure();
      test_steady_stream();
      test_random_traffic();

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d byte/timeout transactions, checked %0d result transactions",
               sent_items, results_seen);
      $display("Replies: %0d delivered good, %0d ended by a fault",
               good_replies, fault_replies);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // watchdog
   initial begin
      while (cycle_count < LIMIT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $error("timeout after %0d cycles, %0d replies still pending", cycle_count,
             pending_replies.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule
